FILE: hdl/tuip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuip_pkg: shared types and constants of the text to unsigned integer parser
// Phase encoding, character codes, field widths and the digit decoder.
// ----------------------------------------------------------------------------
package tuip_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;
    localparam int DIGIT_W = 8;

    // Result beat layout, lowest bit first
    localparam int RES_VALUE_LSB = 0;
    localparam int RES_POS_LSB   = RES_VALUE_LSB + VALUE_W;
    localparam int RES_OVF_BIT   = RES_POS_LSB + POS_W;
    localparam int RES_HAD_BIT   = RES_OVF_BIT + 1;
    localparam int RES_USED_W    = RES_HAD_BIT + 1;
    localparam int RES_TDATA_W   = ((RES_USED_W + 7) / 8) * 8;

    // Scan limit: 65535, the largest value a POS_W offset can hold
    localparam logic [POS_W-1:0] SCAN_LIMIT = 16'hFFFF;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [DIGIT_W-1:0] NOT_DIGIT = 8'hFF;

    // Bases
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // Value of a digit or letter, NOT_DIGIT for anything else
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NOT_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end
        return d;
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: hdl/text_to_unsigned_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_unsigned_integer_parser: streaming strtoul-style number parser
// Takes one text byte per beat and emits value, stop offset and flags when
// the number ends. A multiply-add by the base updates the value.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the byte that ends the number.
// Throughput: one byte per cycle while no result beat is stalled; the 32x6
//   multiply-add and its overflow compare run from the state registers back.
// Reset: aresetn (synchronous, active low) clears the parser to idle, the
//   base register to 0 (auto-detect) and drops any pending result beat.

module text_to_unsigned_integer_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,  // number_base
    // Byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] char_in
    input  logic        s_tuser,      // [0] start_req
    // Result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata       // [31:0] value, [47:32] stop_offset,
                                      // [48] overflow, [49] had_digits, rest 0
);

    localparam int VW = tuip_pkg::VALUE_W;
    localparam int BW = tuip_pkg::BASE_W;
    localparam int PW = tuip_pkg::POS_W;
    localparam int MW = VW + BW + 1;

    // State
    logic [BW-1:0]    number_base_reg;
    tuip_pkg::phase_t phase_reg, phase_next;
    logic [VW-1:0]    acc_reg, acc_next;
    logic [BW-1:0]    base_reg, base_next;
    logic             minus_reg, minus_next;
    logic             ovf_reg, ovf_next;
    logic             dseen_reg, dseen_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic             m_valid_reg;
    logic [tuip_pkg::RES_TDATA_W-1:0] m_data_reg, m_data_next;

    // Effective state after a start beat clears it
    tuip_pkg::phase_t eff_phase;
    logic [VW-1:0]    eff_acc;
    logic [BW-1:0]    eff_base;
    logic             eff_minus, eff_ovf, eff_dseen;
    logic [PW-1:0]    eff_pos;

    logic [tuip_pkg::CHAR_W-1:0]  c;
    logic [tuip_pkg::DIGIT_W-1:0] dval;
    logic                         s_accept;
    logic                         emit, take, force_dseen, digit_ok;
    logic [MW-1:0]                mac;
    logic [VW-1:0]                res_value;
    logic [PW-1:0]                res_pos;
    logic                         res_dseen;

    assign c        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Apply start: a new string discards any open conversion
    always_comb begin
        if (s_tuser) begin
            eff_phase = tuip_pkg::PH_LEAD;
            eff_acc   = '0;
            eff_base  = number_base_reg;
            eff_minus = 1'b0;
            eff_ovf   = 1'b0;
            eff_dseen = 1'b0;
            eff_pos   = '0;
        end else begin
            eff_phase = phase_reg;
            eff_acc   = acc_reg;
            eff_base  = base_reg;
            eff_minus = minus_reg;
            eff_ovf   = ovf_reg;
            eff_dseen = dseen_reg;
            eff_pos   = pos_reg;
        end
    end

    // Next phase, base and sign; decide whether the byte is a digit or ends
    always_comb begin
        phase_next  = eff_phase;
        base_next   = eff_base;
        minus_next  = eff_minus;
        take        = 1'b0;
        force_dseen = 1'b0;
        emit        = 1'b0;
        if (eff_phase != tuip_pkg::PH_IDLE) begin
            if (eff_pos >= tuip_pkg::SCAN_LIMIT) begin
                emit = 1'b1;
            end else begin
                case (eff_phase)
                    tuip_pkg::PH_LEAD,
                    tuip_pkg::PH_SIGNED: begin
                        if (eff_phase == tuip_pkg::PH_LEAD && tuip_pkg::is_blank(c)) begin
                            phase_next = eff_phase;
                        end else if (eff_phase == tuip_pkg::PH_LEAD
                                     && c == tuip_pkg::CH_MINUS) begin
                            minus_next = 1'b1;
                            phase_next = tuip_pkg::PH_SIGNED;
                        end else if (eff_phase == tuip_pkg::PH_LEAD
                                     && c == tuip_pkg::CH_PLUS) begin
                            phase_next = tuip_pkg::PH_SIGNED;
                        end else if (c == tuip_pkg::CH_ZERO
                                     && (eff_base == tuip_pkg::BASE_AUTO
                                         || eff_base == tuip_pkg::BASE_HEX)) begin
                            phase_next = tuip_pkg::PH_ZERO;
                        end else begin
                            if (eff_base == tuip_pkg::BASE_AUTO) begin
                                base_next = tuip_pkg::BASE_DEC;
                            end
                            phase_next = tuip_pkg::PH_DIGITS;
                            take       = 1'b1;
                        end
                    end
                    tuip_pkg::PH_ZERO: begin
                        phase_next = tuip_pkg::PH_DIGITS;
                        if (c == tuip_pkg::CH_LO_X || c == tuip_pkg::CH_UP_X) begin
                            base_next = tuip_pkg::BASE_HEX;
                        end else begin
                            if (eff_base == tuip_pkg::BASE_AUTO) begin
                                base_next = tuip_pkg::BASE_OCT;
                            end
                            force_dseen = 1'b1;
                            take        = 1'b1;
                        end
                    end
                    tuip_pkg::PH_DIGITS: begin
                        take = 1'b1;
                    end
                    default: begin
                        phase_next = tuip_pkg::PH_IDLE;
                    end
                endcase
                if (take && !digit_ok) begin
                    emit = 1'b1;
                end
            end
        end
        if (emit) begin
            phase_next = tuip_pkg::PH_IDLE;
        end
    end

    // Digit decode and multiply-add with overflow check
    assign dval     = tuip_pkg::digit_value(c);
    assign digit_ok = dval < {2'b00, base_next};
    assign mac      = {{(BW+1){1'b0}}, eff_acc} * {{(VW+1){1'b0}}, base_next}
                    + {{(MW-BW){1'b0}}, dval[BW-1:0]};

    always_comb begin
        acc_next   = eff_acc;
        ovf_next   = eff_ovf;
        dseen_next = eff_dseen | force_dseen;
        pos_next   = eff_pos;
        if (take && !emit) begin
            dseen_next = 1'b1;
            if (!eff_ovf) begin
                if (mac[MW-1:VW] != '0) begin
                    ovf_next = 1'b1;
                end else begin
                    acc_next = mac[VW-1:0];
                end
            end
        end
        if (eff_phase != tuip_pkg::PH_IDLE && !emit && eff_pos != tuip_pkg::SCAN_LIMIT) begin
            pos_next = eff_pos + 1'b1;
        end
    end

    // Result fields
    always_comb begin
        res_dseen = eff_dseen | force_dseen;
        if (eff_ovf) begin
            res_value = '1;
        end else if (eff_minus) begin
            res_value = '0 - eff_acc;
        end else begin
            res_value = eff_acc;
        end
        res_pos     = res_dseen ? eff_pos : '0;
        m_data_next = '0;
        m_data_next[tuip_pkg::RES_VALUE_LSB +: VW] = res_value;
        m_data_next[tuip_pkg::RES_POS_LSB +: PW]   = res_pos;
        m_data_next[tuip_pkg::RES_OVF_BIT]         = eff_ovf;
        m_data_next[tuip_pkg::RES_HAD_BIT]         = res_dseen;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= tuip_pkg::BASE_AUTO;
        end else if (cfg_wr_en) begin
            number_base_reg <= cfg_wr_data;
        end
    end

    // Advance the parser state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tuip_pkg::PH_IDLE;
            acc_reg   <= '0;
            base_reg  <= '0;
            minus_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            dseen_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            minus_reg <= minus_next;
            ovf_reg   <= ovf_next;
            dseen_reg <= dseen_next;
            pos_reg   <= pos_next;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

FILE: hdl/tuip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuip_checker: port-level checks for the text to unsigned integer parser
// Watches the stream ports and flags result beats that break the rules.
// ----------------------------------------------------------------------------
module tuip_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A stalled result beat holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset drops any pending result
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // With no result pending the input side is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Overflow saturates the value to all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[tuip_pkg::RES_OVF_BIT]
        |-> m_tdata[tuip_pkg::RES_POS_LSB-1:tuip_pkg::RES_VALUE_LSB] == '1)
        else $error("overflow without saturated value");

    // No digits: zero value, zero offset, no overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[tuip_pkg::RES_HAD_BIT]
        |-> m_tdata[tuip_pkg::RES_OVF_BIT:tuip_pkg::RES_VALUE_LSB] == '0)
        else $error("non-zero result without digits");

endmodule

bind text_to_unsigned_integer_parser tuip_checker u_tuip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/text_to_unsigned_integer_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_unsigned_integer_parser_tb: self-checking bench of the number parser
// Streams text strings byte by byte into the parser under several base
// settings. A behavioural parser in the bench predicts each result beat, and
// a checker compares every beat field by field. Short directed strings cover
// the corner cases. Random strings then follow, with random gaps on the input
// side and random stalls on the result side.
// ----------------------------------------------------------------------------

module text_to_unsigned_integer_parser_tb;

    localparam int RANDOM_BYTES = 980;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [tuip_pkg::VALUE_W-1:0] value;
        logic [tuip_pkg::POS_W-1:0]   stop_offset;
        logic                         overflow;
        logic                         had_digits;
    } number_t;

    // DUT signals, all inputs known from time zero
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;    // [7:0] char_in
    logic        s_tuser     = 1'b0;  // [0] start_req
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [55:0] m_tdata;             // [31:0] value, [47:32] stop_offset,
                                      // [48] overflow, [49] had_digits

    // Parser state mirrored by the bench
    tuip_pkg::phase_t             scan_phase   = tuip_pkg::PH_IDLE;
    logic [tuip_pkg::VALUE_W-1:0] scan_acc     = '0;
    logic [tuip_pkg::BASE_W-1:0]  scan_radix   = '0;
    logic                         scan_neg     = 1'b0;
    logic                         scan_ovf     = 1'b0;
    logic                         scan_digits  = 1'b0;
    logic [tuip_pkg::POS_W-1:0]   scan_pos     = '0;
    logic [tuip_pkg::BASE_W-1:0]  base_setting = tuip_pkg::BASE_AUTO;

    number_t     pending_numbers[$];
    logic [7:0]  line_bytes[$];
    int          error_count     = 0;
    int          text_bytes_sent = 0;
    bit          gaps_on         = 1'b1;
    int          ready_left      = 0;
    int          stall_left      = 0;
    bit          ready_steady    = 1'b0;

    text_to_unsigned_integer_parser u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [7:0] char_digit(input logic [7:0] c);
        if (c >= tuip_pkg::CH_ZERO && c <= tuip_pkg::CH_NINE)
            return c - tuip_pkg::CH_ZERO;
        if (c >= tuip_pkg::CH_UP_A && c <= tuip_pkg::CH_UP_Z)
            return c - tuip_pkg::CH_UP_A + 8'd10;
        if (c >= tuip_pkg::CH_LO_A && c <= tuip_pkg::CH_LO_Z)
            return c - tuip_pkg::CH_LO_A + 8'd10;
        return tuip_pkg::NOT_DIGIT;
    endfunction

    // Advance the mirrored parser by one accepted byte
    task automatic parse_byte(input logic [7:0] c, input logic start,
                              output bit emitted, output number_t res);
        logic [7:0]  d;
        logic [63:0] prod;
        bit          finish_now;
        bit          take;
        bit          begin_num;
        emitted    = 1'b0;
        res        = '0;
        finish_now = 1'b0;
        take       = 1'b0;
        begin_num  = 1'b0;
        if (start) begin
            scan_phase  = tuip_pkg::PH_LEAD;
            scan_acc    = '0;
            scan_radix  = base_setting;
            scan_neg    = 1'b0;
            scan_ovf    = 1'b0;
            scan_digits = 1'b0;
            scan_pos    = '0;
        end
        if (scan_phase == tuip_pkg::PH_IDLE) return;

        if (scan_pos == tuip_pkg::SCAN_LIMIT) begin
            finish_now = 1'b1;
        end else begin
            case (scan_phase)
                tuip_pkg::PH_LEAD: begin
                    if (c == tuip_pkg::CH_SPACE
                        || (c >= tuip_pkg::CH_TAB && c <= tuip_pkg::CH_CR)) begin
                        // skip blanks
                    end else if (c == tuip_pkg::CH_MINUS) begin
                        scan_neg   = 1'b1;
                        scan_phase = tuip_pkg::PH_SIGNED;
                    end else if (c == tuip_pkg::CH_PLUS) begin
                        scan_phase = tuip_pkg::PH_SIGNED;
                    end else begin
                        begin_num = 1'b1;
                    end
                end
                tuip_pkg::PH_SIGNED: begin
                    begin_num = 1'b1;
                end
                tuip_pkg::PH_ZERO: begin
                    if (c == tuip_pkg::CH_LO_X || c == tuip_pkg::CH_UP_X) begin
                        scan_radix = tuip_pkg::BASE_HEX;
                        scan_phase = tuip_pkg::PH_DIGITS;
                    end else begin
                        if (scan_radix == tuip_pkg::BASE_AUTO) scan_radix = tuip_pkg::BASE_OCT;
                        scan_digits = 1'b1;
                        scan_phase  = tuip_pkg::PH_DIGITS;
                        take        = 1'b1;
                    end
                end
                default: begin
                    take = 1'b1;
                end
            endcase

            // A leading zero may open a hex prefix; anything else is a digit
            if (begin_num) begin
                if (c == tuip_pkg::CH_ZERO && (scan_radix == tuip_pkg::BASE_AUTO
                                               || scan_radix == tuip_pkg::BASE_HEX)) begin
                    scan_phase = tuip_pkg::PH_ZERO;
                end else begin
                    if (scan_radix == tuip_pkg::BASE_AUTO) scan_radix = tuip_pkg::BASE_DEC;
                    scan_phase = tuip_pkg::PH_DIGITS;
                    take       = 1'b1;
                end
            end

            // Accumulate, keep consuming once saturated
            if (take) begin
                d = char_digit(c);
                if (d >= scan_radix) begin
                    finish_now = 1'b1;
                end else begin
                    if (!scan_ovf) begin
                        prod = 64'(scan_acc) * 64'(scan_radix) + 64'(d);
                        if (prod > 64'hFFFF_FFFF) scan_ovf = 1'b1;
                        else scan_acc = prod[31:0];
                    end
                    scan_digits = 1'b1;
                end
            end
        end

        if (finish_now) begin
            if (scan_ovf) res.value = '1;
            else if (scan_neg) res.value = 32'd0 - scan_acc;
            else res.value = scan_acc;
            res.stop_offset = scan_digits ? scan_pos : '0;
            res.overflow    = scan_ovf;
            res.had_digits  = scan_digits;
            scan_phase      = tuip_pkg::PH_IDLE;
            emitted         = 1'b1;
        end else if (scan_pos != 16'hFFFF) begin
            scan_pos = scan_pos + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        error_count++;
    endtask

    // Predict on accepted bytes, compare each accepted result beat
    always @(posedge aclk) begin : result_check
        number_t predicted;
        number_t got;
        bit      produced;
        if (!aresetn) begin
            scan_phase   = tuip_pkg::PH_IDLE;
            scan_acc     = '0;
            scan_radix   = '0;
            scan_neg     = 1'b0;
            scan_ovf     = 1'b0;
            scan_digits  = 1'b0;
            scan_pos     = '0;
            base_setting = tuip_pkg::BASE_AUTO;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tuser, produced, predicted);
                if (produced) pending_numbers.push_back(predicted);
            end
            if (cfg_wr_en) base_setting = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.value       = m_tdata[tuip_pkg::RES_VALUE_LSB +: tuip_pkg::VALUE_W];
                got.stop_offset = m_tdata[tuip_pkg::RES_POS_LSB +: tuip_pkg::POS_W];
                got.overflow    = m_tdata[tuip_pkg::RES_OVF_BIT];
                got.had_digits  = m_tdata[tuip_pkg::RES_HAD_BIT];
                if (m_tdata[55:tuip_pkg::RES_USED_W] != '0)
                    report_mismatch("padding bits", m_tdata[55:tuip_pkg::RES_USED_W], 0);
                if (pending_numbers.size() == 0) begin
                    report_mismatch("result beat with none due", got.value, 0);
                end else begin
                    predicted = pending_numbers.pop_front();
                    if (got.value != predicted.value)
                        report_mismatch("value", got.value, predicted.value);
                    if (got.stop_offset != predicted.stop_offset)
                        report_mismatch("stop_offset", got.stop_offset,
                                        predicted.stop_offset);
                    if (got.overflow != predicted.overflow)
                        report_mismatch("overflow", got.overflow, predicted.overflow);
                    if (got.had_digits != predicted.had_digits)
                        report_mismatch("had_digits", got.had_digits,
                                        predicted.had_digits);
                end
            end
        end
    end

    // Result side backpressure: steady stretches and random stalls
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_steady = ($urandom_range(0, 2) == 0);
            ready_left   = $urandom_range(16, 160);
        end else begin
            ready_left--;
        end
        if (ready_steady) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < 55) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Present one byte and hold it until the parser takes the beat
    task automatic send_byte(input logic [7:0] c, input logic start);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Send the bytes in line_bytes as one string
    task automatic send_text();
        foreach (line_bytes[i]) send_byte(line_bytes[i], i == 0);
        text_bytes_sent += line_bytes.size();
    endtask

    task automatic send_str(input string s);
        line_bytes.delete();
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
        send_text();
    endtask

    // Hold off the sender until all predicted results arrive or DRAIN_LIMIT ends
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        foreach (pending_numbers[i])
            report_mismatch("result never came", 0, pending_numbers[i].value);
        pending_numbers.delete();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_base(input logic [5:0] b);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? tuip_pkg::CH_SPACE : tuip_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return tuip_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? tuip_pkg::CH_UP_A : tuip_pkg::CH_LO_A) + 8'(v - 10);
    endfunction

    // Fill line_bytes with a well-formed number for the given base setting
    task automatic build_number(input logic [5:0] base);
        int  lim;
        int  n_dig;
        int  r;
        int  v;
        bit  nonzero_first;
        line_bytes.delete();
        nonzero_first = 1'b0;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) line_bytes.push_back(blank_char());
        r = $urandom_range(0, 5);
        if (r == 0) line_bytes.push_back(tuip_pkg::CH_MINUS);
        else if (r == 1) line_bytes.push_back(tuip_pkg::CH_PLUS);

        lim = base;
        if (base == tuip_pkg::BASE_AUTO) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                line_bytes.push_back(tuip_pkg::CH_ZERO);
                line_bytes.push_back($urandom_range(0, 1) ? tuip_pkg::CH_LO_X
                                                          : tuip_pkg::CH_UP_X);
                lim = 16;
            end else if (r == 1) begin
                line_bytes.push_back(tuip_pkg::CH_ZERO);
                lim = 8;
            end else begin
                lim = 10;
                nonzero_first = 1'b1;
            end
        end else if (base == tuip_pkg::BASE_HEX && $urandom_range(0, 1)) begin
            line_bytes.push_back(tuip_pkg::CH_ZERO);
            line_bytes.push_back($urandom_range(0, 1) ? tuip_pkg::CH_LO_X
                                                      : tuip_pkg::CH_UP_X);
        end
        if (lim > 36) lim = 36;

        if ($urandom_range(0, 15) == 0) n_dig = 0;
        else if ($urandom_range(0, 7) == 0) n_dig = $urandom_range(8, 36);
        else n_dig = $urandom_range(1, 6);
        for (int i = 0; i < n_dig; i++) begin
            if (nonzero_first && i == 0) v = $urandom_range(1, 9);
            else v = (lim <= 1) ? 0 : $urandom_range(0, lim - 1);
            line_bytes.push_back(digit_char(v));
        end

        // Stopping byte
        r = $urandom_range(0, 3);
        if (r == 0) line_bytes.push_back(8'($urandom_range(0, 255)));
        else if (r == 1) line_bytes.push_back(blank_char());
        else if (r == 2 && lim < 36) line_bytes.push_back(digit_char($urandom_range(lim, 35)));
        else line_bytes.push_back(8'($urandom_range(128, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Prefix detection, signs, octal, overflow and the extremes of a byte
    task automatic test_auto_base();
        write_base(tuip_pkg::BASE_AUTO);
        send_byte("7", 1'b0);          // no string open: ignored
        send_str("\t-0x1F ");
        send_str("+0179");             // octal stops at the 9
        send_str("0Xg");               // prefix with no hex digit
        send_str("0!");                // lone leading zero
        send_str("12");                // dropped by the next start
        send_str("5;");
        send_str("4294967295");
        send_byte(8'hFF, 1'b0);
        send_str("4294967296");
        send_byte(8'h80, 1'b0);
    endtask

    // Fixed bases including base one and a base above 36
    task automatic test_fixed_bases();
        write_base(6'd1);
        send_str("00+");
        write_base(6'd2);
        send_str("-1012");
        write_base(tuip_pkg::BASE_HEX);
        send_str("0x0x");
        send_str("0ffffffffF");
        write_base(6'd36);
        send_str("zZ9.");
        write_base(6'd63);
        send_str("zZ{");
    endtask

    // Mostly well-formed numbers, some cut short, some noise
    task automatic test_random_strings();
        logic [5:0] base;
        int         r;
        text_bytes_sent = 0;
        while (text_bytes_sent < RANDOM_BYTES) begin
            r = $urandom_range(0, 9);
            case (r)
                0, 1:    base = tuip_pkg::BASE_AUTO;
                2:       base = tuip_pkg::BASE_DEC;
                3:       base = tuip_pkg::BASE_HEX;
                4:       base = tuip_pkg::BASE_OCT;
                5:       base = 6'd2;
                6:       base = 6'd36;
                default: base = 6'($urandom_range(0, 63));
            endcase
            write_base(base);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(10, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    build_number(base);
                    send_text();
                    repeat ($urandom_range(0, 2))
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end else if (r < 88) begin
                    // cut short: the next start drops it
                    build_number(base);
                    if (line_bytes.size() > 1)
                        repeat ($urandom_range(1, line_bytes.size() - 1))
                            void'(line_bytes.pop_back());
                    send_text();
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                        text_bytes_sent++;
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_auto_base();
        test_fixed_bases();
        test_random_strings();
        drain_results();

        if (error_count == 0) begin
            $display("text_to_unsigned_integer_parser_tb: PASS");
        end else begin
            $display("text_to_unsigned_integer_parser_tb: FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10ms;
        $display("text_to_unsigned_integer_parser_tb: FAIL");
        $finish;
    end

endmodule
